// ----- sv/cdd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date distance package
// Field widths, calendar constants and month tables shared by the core.
// ----------------------------------------------------------------------------
package cdd_pkg;

  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned DIST_W   = 22;
  // day count of 31 Dec of the largest representable year needs 23 bits
  localparam int unsigned DAYNUM_W = 23;
  localparam int unsigned DBM_W    = 9;
  localparam int unsigned CENT_W   = 8;

  localparam logic [YEAR_W-1:0]   YEAR_MAX     = YEAR_W'(9999);
  localparam logic [DAYNUM_W-1:0] DAYS_IN_YEAR = DAYNUM_W'(365);
  localparam logic [DIST_W-1:0]   DIST_MAX     = '1;

  // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT, exact for x below 4096
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned PROD_W      = (YEAR_W - 2) + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(5243);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = DAY_W'(29);

  typedef struct packed {
    logic                ok;
    logic [DAYNUM_W-1:0] num;
  } date_info_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                       len = DAY_W'(28);
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DBM_W-1:0] n;
    unique case (m)
      4'd2:    n = DBM_W'(31);
      4'd3:    n = DBM_W'(59);
      4'd4:    n = DBM_W'(90);
      4'd5:    n = DBM_W'(120);
      4'd6:    n = DBM_W'(151);
      4'd7:    n = DBM_W'(181);
      4'd8:    n = DBM_W'(212);
      4'd9:    n = DBM_W'(243);
      4'd10:   n = DBM_W'(273);
      4'd11:   n = DBM_W'(304);
      4'd12:   n = DBM_W'(334);
      default: n = '0;
    endcase
    return n;
  endfunction

  // floor(y / 100) through a reciprocal multiply by a constant
  function automatic logic [CENT_W-1:0] div100(input logic [YEAR_W-1:0] y);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(y[YEAR_W-1:2]) * PROD_W'(RECIP_25);
    return prod[RECIP_SHIFT +: CENT_W];
  endfunction

endpackage
`default_nettype wire

// ----- sv/cdd_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date distance channels
// Valid/ready channels for the date pair item and the distance item.
// ----------------------------------------------------------------------------
interface cdd_in_if;
  logic                         valid;
  logic                         ready;
  logic [cdd_pkg::DAY_W-1:0]    first_day;
  logic [cdd_pkg::MONTH_W-1:0]  first_month;
  logic [cdd_pkg::YEAR_W-1:0]   first_year;
  logic [cdd_pkg::DAY_W-1:0]    second_day;
  logic [cdd_pkg::MONTH_W-1:0]  second_month;
  logic [cdd_pkg::YEAR_W-1:0]   second_year;

  modport source (
    output valid, first_day, first_month, first_year,
    output second_day, second_month, second_year,
    input  ready
  );
  modport sink (
    input  valid, first_day, first_month, first_year,
    input  second_day, second_month, second_year,
    output ready
  );
endinterface

interface cdd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        both_valid;
  logic [cdd_pkg::DIST_W-1:0]  day_distance;

  modport source (
    output valid, both_valid, day_distance,
    input  ready
  );
  modport sink (
    input  valid, both_valid, day_distance,
    output ready
  );
endinterface
`default_nettype wire

// ----- sv/calendar_date_distance_core.sv -----
// Path: an accepted item is held in the input register, then in the result
//   register, where its result is offered; a stalled result handshake holds
//   it there.
// Throughput: one item per cycle while out_o.ready is not held low; the single
//   pass of day-number logic between the two registers sets the figure.
// Reset: rst_ni clears both stage valid flags; payload registers keep data.
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date distance core
// Absolute distance in days between two Gregorian dates, with validity flag.
// ----------------------------------------------------------------------------
module calendar_date_distance_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdd_in_if.sink     in_i,
  cdd_out_if.source  out_o
);
  import cdd_pkg::*;

  logic                  s1_valid_q;
  logic [DAY_W-1:0]      d1_q, d2_q;
  logic [MONTH_W-1:0]    m1_q, m2_q;
  logic [YEAR_W-1:0]     y1_q, y2_q;
  logic                  s1_ready;
  logic                  in_take;

  logic                  out_valid_q;
  logic                  both_valid_q, both_valid_d;
  logic [DIST_W-1:0]     dist_q, dist_d;

  date_info_t            info1, info2;
  logic [DAYNUM_W-1:0]   diff;

  assign s1_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_ready;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      d1_q <= in_i.first_day;
      m1_q <= in_i.first_month;
      y1_q <= in_i.first_year;
      d2_q <= in_i.second_day;
      m2_q <= in_i.second_month;
      y2_q <= in_i.second_year;
    end
  end

  cdd_day_number u_first (
    .day_i   (d1_q),
    .month_i (m1_q),
    .year_i  (y1_q),
    .info_o  (info1)
  );

  cdd_day_number u_second (
    .day_i   (d2_q),
    .month_i (m2_q),
    .year_i  (y2_q),
    .info_o  (info2)
  );

  assign diff = (info1.num >= info2.num) ? (info1.num - info2.num)
                                         : (info2.num - info1.num);

  always_comb begin
    both_valid_d = info1.ok && info2.ok;
    if (!both_valid_d) begin
      dist_d = '0;
    end else if (diff > DAYNUM_W'(DIST_MAX)) begin
      dist_d = DIST_MAX;
    end else begin
      dist_d = diff[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s1_valid_q) begin
      both_valid_q <= both_valid_d;
      dist_q       <= dist_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.both_valid   = both_valid_q;
  assign out_o.day_distance = dist_q;

  // an item in the input stage moves to the result register when it is free
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_ready |=> out_valid_q)
    else $error("item lost between input and result register");

  // an accepted item lands in the input stage
  a_in_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted item not held in input stage");

  // invalid dates give a zero distance
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !both_valid_q |-> dist_q == '0)
    else $error("nonzero distance for invalid dates");

  // identical dates give a zero distance
  a_same_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_ready && d1_q == d2_q && m1_q == m2_q && y1_q == y2_q
    |=> dist_q == '0)
    else $error("nonzero distance for identical dates");

endmodule
`default_nettype wire

// ----- sv/cdd_day_number.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Day number of one date
// Checks a Gregorian date and converts it to a day count from 1 Jan of year 1.
// ----------------------------------------------------------------------------
module cdd_day_number (
  input  logic [cdd_pkg::DAY_W-1:0]   day_i,
  input  logic [cdd_pkg::MONTH_W-1:0] month_i,
  input  logic [cdd_pkg::YEAR_W-1:0]  year_i,
  output cdd_pkg::date_info_t         info_o
);
  import cdd_pkg::*;

  logic [YEAR_W-1:0] prev_year;
  logic [CENT_W-1:0] cent_year;
  logic [CENT_W-1:0] cent_prev;
  logic              div4;
  logic              div100_hit;
  logic              div400_hit;
  logic              leap;
  logic [DAY_W-1:0]  len;
  logic              year_ok;
  logic              month_ok;
  logic              day_ok;

  assign prev_year = year_i - YEAR_W'(1);
  assign cent_year = div100(year_i);
  assign cent_prev = div100(prev_year);

  // y is a multiple of 100 (400) exactly when y/100 (y/400) steps from y-1
  assign div4       = (year_i[1:0] == 2'b00);
  assign div100_hit = (cent_year != cent_prev);
  assign div400_hit = (cent_year[CENT_W-1:2] != cent_prev[CENT_W-1:2]);
  assign leap       = div400_hit || (div4 && !div100_hit);

  assign len      = (month_i == MONTH_FEB && leap) ? FEB_LEAP_LEN : month_len(month_i);
  assign year_ok  = (year_i != '0) && (year_i <= YEAR_MAX);
  assign month_ok = (month_i >= MONTH_JAN) && (month_i <= MONTH_DEC);
  assign day_ok   = (day_i != '0) && (day_i <= len);

  assign info_o.ok  = year_ok && month_ok && day_ok;
  assign info_o.num = DAYNUM_W'(prev_year) * DAYS_IN_YEAR
                    + DAYNUM_W'(prev_year[YEAR_W-1:2])
                    - DAYNUM_W'(cent_prev)
                    + DAYNUM_W'(cent_prev[CENT_W-1:2])
                    + DAYNUM_W'(days_before(month_i))
                    + DAYNUM_W'(leap && (month_i > MONTH_FEB))
                    + DAYNUM_W'(day_i);

endmodule
`default_nettype wire
